>>> design/psg_es_pkg.sv
// shared types, constants and helpers of the sound-effect sequencer
package psg_es_pkg;

  localparam int VOICES        = 3;
  localparam int MAX_STEPS_DEF = 32;
  localparam int QW            = 17;

  localparam logic [QW-1:0] SPK_CLOCK  = 17'd125000;
  localparam logic [11:0]   PERIOD_MAX = 12'hFFF;
  localparam logic [16:0]   TICK_MS    = 17'd20;
  localparam logic [15:0]   MIN_DUR    = 16'd10;
  localparam logic [3:0]    LEVEL_MAX  = 4'd15;

  localparam logic [3:0] REG_TONE_A_LO = 4'd0;
  localparam logic [3:0] REG_TONE_A_HI = 4'd1;
  localparam logic [3:0] REG_NOISE     = 4'd6;
  localparam logic [3:0] REG_MIXER     = 4'd7;
  localparam logic [3:0] REG_VOL_A     = 4'd8;

  localparam logic [7:0] MIX_SPK_VAL  = 8'h08;
  localparam logic [5:0] MIX_SPK_MASK = 6'h09;
  localparam logic [5:0] MIX_V_MASK   = 6'h09;

  localparam logic [1:0] VOICE_AUTO = 2'd3;
  localparam logic       ERR_BAD    = 1'b0;
  localparam logic       ERR_BUSY   = 1'b1;

  typedef enum logic [2:0] {
    CMD_TICK    = 3'd0,
    CMD_LOAD    = 3'd1,
    CMD_PLAY    = 3'd2,
    CMD_STOP    = 3'd3,
    CMD_SPEAKER = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    K_WRITE   = 3'd0,
    K_MIXER   = 3'd1,
    K_RELEASE = 3'd2,
    K_ACCEPT  = 3'd3,
    K_REFUSE  = 3'd4,
    K_DONE    = 3'd5
  } kind_t;

  typedef enum logic [3:0] {
    S_IDLE, S_ACK, S_DONE, S_DIV, S_SPK, S_SPK_STOP, S_SPK_WR,
    S_VSTOP, S_VPLAY, S_ADV, S_RD, S_STEP, S_VNOISE
  } state_t;

  typedef struct packed {
    logic          busy;
    logic          done;
    logic [QW-1:0] quot;
  } div_res_t;

  function automatic logic [3:0] clamp_level(input logic [7:0] x);
    return (x > {4'd0, LEVEL_MAX}) ? LEVEL_MAX : x[3:0];
  endfunction

endpackage

>>> design/psg_es_store.sv
// step entry memory, one write port and one registered read port
module psg_es_store #(
  parameter int DEPTH = psg_es_pkg::VOICES * psg_es_pkg::MAX_STEPS_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [15:0]   wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [15:0]   rd_data
);

  logic [15:0] mem [0:DEPTH-1];
  logic [15:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> design/psg_es_div.sv
// bit-serial divider for the speaker period, one quotient bit a cycle
module psg_es_div (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [15:0]          divisor,
  output psg_es_pkg::div_res_t res
);

  logic                      busy_r, busy_nxt;
  logic                      done_r, done_nxt;
  logic [4:0]                cnt_r, cnt_nxt;
  logic [15:0]               rem_r, rem_nxt;
  logic [15:0]               den_r, den_nxt;
  logic [psg_es_pkg::QW-1:0] quot_r, quot_nxt;
  logic [16:0]               rem_sh;
  logic                      ge;

  always_comb begin
    rem_sh   = {rem_r, quot_r[psg_es_pkg::QW-1]};
    ge       = rem_sh >= {1'b0, den_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quot_nxt = quot_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 5'(psg_es_pkg::QW - 1);
      rem_nxt  = '0;
      den_nxt  = divisor;
      quot_nxt = psg_es_pkg::SPK_CLOCK;
    end else if (busy_r) begin
      rem_nxt  = ge ? 16'(rem_sh - {1'b0, den_r}) : rem_sh[15:0];
      quot_nxt = {quot_r[psg_es_pkg::QW-2:0], ge};
      cnt_nxt  = cnt_r - 5'd1;
      if (cnt_r == 5'd0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r  <= cnt_nxt;
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
    quot_r <= quot_nxt;
  end

  assign res.busy = busy_r;
  assign res.done = done_r;
  assign res.quot = quot_r;

endmodule

>>> design/psg_effect_sequencer_core.sv
// Three-voice sound-effect sequencer for a programmable sound generator.
// Input channel in_*: one word per command (tick, load step, play, stop,
// speaker tone). in_stall stays high from the accepted word until its last
// result has been handed to the output register.
// Output channel out_*: result words in order; every command ends with a
// done word that carries out_last.
// Load, stop and unknown commands go straight to the done word; play emits
// its acknowledge word and then done; a speaker tone with a nonzero frequency
// first waits for the serial 17-bit divider. A tick walks the speaker and then
// each voice, emitting its words and reading the step memory once per played
// step. The step memory read port and the single output register set the pace.
// Reset clears voice run, pending, stop and ownership flags and the speaker
// period and flags. Step entries are undefined until loaded; a play must
// only reach loaded entries. While out_stall is high the current word is held;
// only the idle state and the divider wait advance until it is taken.
module psg_effect_sequencer_core #(
  parameter int MAX_STEPS = psg_es_pkg::MAX_STEPS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_command,
  input  logic [1:0]  in_voice_sel,
  input  logic [4:0]  in_slot_index,
  input  logic [11:0] in_tone_period,
  input  logic [7:0]  in_level,
  input  logic        in_use_level_table,
  input  logic [4:0]  in_noise_rate,
  input  logic [5:0]  in_step_total,
  input  logic [15:0] in_step_duration,
  input  logic [15:0] in_tone_freq,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_kind,
  output logic [3:0]  out_reg_addr,
  output logic [7:0]  out_reg_value,
  output logic [5:0]  out_mix_mask,
  output logic [1:0]  out_voice_out,
  output logic        out_error_code,
  output logic [3:0]  out_owned_mask,
  output logic [2:0]  out_active_mask,
  output logic        out_last
);

  localparam int DEPTH = psg_es_pkg::VOICES * MAX_STEPS;
  localparam int AW    = $clog2(DEPTH);
  localparam int SW    = $clog2(MAX_STEPS + 1);

  psg_es_pkg::state_t   state_r, state_nxt;
  psg_es_pkg::cmd_t     cmd;
  psg_es_pkg::div_res_t div_res;
  psg_es_pkg::kind_t    ack_kind_r, ack_kind_nxt;
  psg_es_pkg::kind_t    e_kind;

  logic [1:0]  v_r, v_nxt;
  logic [1:0]  k_r, k_nxt;
  logic        nu_r, nu_nxt, nu_cur;
  logic        from_adv_r, from_adv_nxt;
  logic [2:0]  running_r, running_nxt;
  logic [2:0]  pending_r, pending_nxt;
  logic [2:0]  stopreq_r, stopreq_nxt;
  logic [3:0]  own_r, own_nxt;
  logic [11:0] spk_period_r, spk_period_nxt;
  logic [3:0]  spk_level_r, spk_level_nxt;
  logic        spk_dirty_r, spk_dirty_nxt;
  logic        spk_running_r, spk_running_nxt;
  logic [1:0]  ack_voice_r, ack_voice_nxt;
  logic        ack_err_r, ack_err_nxt;

  logic          pd_table_r [0:2];
  logic [4:0]    pd_noise_r [0:2];
  logic [SW-1:0] pd_total_r [0:2];
  logic [15:0]   pd_dur_r   [0:2];
  logic [3:0]    pd_level_r [0:2];
  logic          ad_table_r [0:2];
  logic [4:0]    ad_noise_r [0:2];
  logic [SW-1:0] ad_total_r [0:2];
  logic [15:0]   ad_dur_r   [0:2];
  logic [3:0]    ad_level_r [0:2];
  logic [SW-1:0] pos_r [0:2];
  logic [SW-1:0] pos_nxt [0:2];
  logic [16:0]   acc_r [0:2];
  logic [16:0]   acc_nxt [0:2];

  logic          in_accept, out_free, adv, commit;
  logic          pd_we, ad_we;
  logic [1:0]    pd_sel;
  logic [SW-1:0] sat_total;
  logic [15:0]   eff_dur;
  logic [2:0]    free_v;
  logic [1:0]    auto_v, play_v;
  logic          play_bad;
  logic          mem_wr_en, mem_rd_en;
  logic [AW-1:0] mem_wr_addr, mem_rd_addr;
  logic [15:0]   mem_rd_data;
  logic          div_start;
  logic [11:0]   step_period;
  logic [3:0]    step_vol;
  logic          step_end;
  logic [15:0]   cur_dur;
  logic          acc_ge;
  logic [SW-1:0] pos_inc;
  logic [11:0]   div_period;

  logic        emit_en, e_err, e_last;
  logic [3:0]  e_addr;
  logic [7:0]  e_val;
  logic [5:0]  e_mask;
  logic [1:0]  e_voice;

  logic [2:0]  out_kind_r;
  logic [3:0]  out_addr_r, out_own_r;
  logic [7:0]  out_val_r;
  logic [5:0]  out_mask_r;
  logic [1:0]  out_voice_r;
  logic        out_err_r, out_last_r, out_valid_r;
  logic [2:0]  out_act_r;

  psg_es_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data ({in_tone_period, psg_es_pkg::clamp_level(in_level)}),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  psg_es_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .divisor (in_tone_freq),
    .res     (div_res)
  );

  assign cmd       = psg_es_pkg::cmd_t'(in_command);
  assign in_stall  = (state_r != psg_es_pkg::S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign adv       = out_free || (state_r == psg_es_pkg::S_DIV);
  assign commit    = (state_r == psg_es_pkg::S_IDLE) || adv;

  // play descriptor checks and voice choice
  always_comb begin
    play_bad  = (in_step_total == 6'd0) || (in_step_duration == 16'd0);
    sat_total = (32'(in_step_total) > MAX_STEPS) ? SW'(MAX_STEPS) : SW'(in_step_total);
    eff_dur   = (in_step_duration < psg_es_pkg::MIN_DUR) ? psg_es_pkg::MIN_DUR
                                                         : in_step_duration;
    for (int i = 0; i < 3; i++) begin
      free_v[i] = !running_r[i] && !pending_r[i];
    end
    free_v[0] = free_v[0] && (spk_period_r == 12'd0);
    if (free_v[2]) begin
      auto_v = 2'd2;
    end else if (free_v[1]) begin
      auto_v = 2'd1;
    end else if (free_v[0]) begin
      auto_v = 2'd0;
    end else begin
      auto_v = 2'd2;
    end
    play_v = (in_voice_sel == psg_es_pkg::VOICE_AUTO) ? auto_v : in_voice_sel;
  end

  always_comb begin
    step_period = mem_rd_data[15:4];
    step_vol    = ad_table_r[v_r] ? mem_rd_data[3:0] : ad_level_r[v_r];
    step_end    = (step_period == 12'd0) ||
                  ((ad_noise_r[v_r] != 5'd0) ? (k_r == 2'd2) : (k_r == 2'd3));
    cur_dur     = (ad_dur_r[v_r] == 16'd0) ? psg_es_pkg::MIN_DUR : ad_dur_r[v_r];
    acc_ge      = acc_r[v_r] >= {1'b0, cur_dur};
    pos_inc     = pos_r[v_r] + SW'(1);
    nu_cur      = nu_r || (running_r[v_r] && (ad_noise_r[v_r] != 5'd0));
    if (div_res.quot > 17'(psg_es_pkg::PERIOD_MAX)) begin
      div_period = psg_es_pkg::PERIOD_MAX;
    end else if (div_res.quot == 17'd0) begin
      div_period = 12'd1;
    end else begin
      div_period = div_res.quot[11:0];
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      psg_es_pkg::S_IDLE: begin
        if (in_accept) begin
          case (cmd)
            psg_es_pkg::CMD_TICK:    state_nxt = psg_es_pkg::S_SPK;
            psg_es_pkg::CMD_PLAY:    state_nxt = psg_es_pkg::S_ACK;
            psg_es_pkg::CMD_SPEAKER: begin
              state_nxt = (in_tone_freq == 16'd0) ? psg_es_pkg::S_DONE : psg_es_pkg::S_DIV;
            end
            default:                 state_nxt = psg_es_pkg::S_DONE;
          endcase
        end
      end
      psg_es_pkg::S_ACK:  state_nxt = psg_es_pkg::S_DONE;
      psg_es_pkg::S_DONE: state_nxt = psg_es_pkg::S_IDLE;
      psg_es_pkg::S_DIV: begin
        if (div_res.done) begin
          state_nxt = psg_es_pkg::S_DONE;
        end
      end
      psg_es_pkg::S_SPK: begin
        if (spk_dirty_r && (spk_period_r != 12'd0)) begin
          state_nxt = psg_es_pkg::S_SPK_STOP;
        end else begin
          state_nxt = psg_es_pkg::S_VSTOP;
        end
      end
      psg_es_pkg::S_SPK_STOP: state_nxt = psg_es_pkg::S_SPK_WR;
      psg_es_pkg::S_SPK_WR: begin
        if (k_r == 2'd3) begin
          state_nxt = psg_es_pkg::S_VSTOP;
        end
      end
      psg_es_pkg::S_VSTOP: state_nxt = psg_es_pkg::S_VPLAY;
      psg_es_pkg::S_VPLAY: begin
        if (pending_r[v_r]) begin
          state_nxt = ((v_r == 2'd0) && spk_running_r) ? psg_es_pkg::S_VNOISE
                                                       : psg_es_pkg::S_RD;
        end else if (running_r[v_r]) begin
          state_nxt = psg_es_pkg::S_ADV;
        end else begin
          state_nxt = psg_es_pkg::S_VNOISE;
        end
      end
      psg_es_pkg::S_ADV: begin
        if (running_r[v_r] && acc_ge) begin
          state_nxt = (pos_inc >= ad_total_r[v_r]) ? psg_es_pkg::S_ADV : psg_es_pkg::S_RD;
        end else begin
          state_nxt = psg_es_pkg::S_VNOISE;
        end
      end
      psg_es_pkg::S_RD: state_nxt = psg_es_pkg::S_STEP;
      psg_es_pkg::S_STEP: begin
        if (step_end) begin
          state_nxt = from_adv_r ? psg_es_pkg::S_ADV : psg_es_pkg::S_VNOISE;
        end
      end
      psg_es_pkg::S_VNOISE: begin
        state_nxt = (v_r == 2'd2) ? psg_es_pkg::S_DONE : psg_es_pkg::S_VSTOP;
      end
      default: state_nxt = psg_es_pkg::S_IDLE;
    endcase
  end

  // state updates and result words
  always_comb begin
    v_nxt           = v_r;
    k_nxt           = k_r;
    nu_nxt          = nu_r;
    from_adv_nxt    = from_adv_r;
    running_nxt     = running_r;
    pending_nxt     = pending_r;
    stopreq_nxt     = stopreq_r;
    own_nxt         = own_r;
    spk_period_nxt  = spk_period_r;
    spk_level_nxt   = spk_level_r;
    spk_dirty_nxt   = spk_dirty_r;
    spk_running_nxt = spk_running_r;
    ack_kind_nxt    = ack_kind_r;
    ack_voice_nxt   = ack_voice_r;
    ack_err_nxt     = ack_err_r;
    pos_nxt         = pos_r;
    acc_nxt         = acc_r;
    pd_we           = 1'b0;
    pd_sel          = play_v;
    ad_we           = 1'b0;
    mem_wr_en       = 1'b0;
    mem_wr_addr     = AW'(32'(in_voice_sel) * MAX_STEPS + 32'(in_slot_index));
    mem_rd_en       = 1'b0;
    mem_rd_addr     = AW'(32'(v_r) * MAX_STEPS + 32'(pos_r[v_r]));
    div_start       = 1'b0;
    emit_en         = 1'b0;
    e_kind          = psg_es_pkg::K_DONE;
    e_addr          = 4'd0;
    e_val           = 8'd0;
    e_mask          = 6'd0;
    e_voice         = 2'd0;
    e_err           = 1'b0;
    e_last          = 1'b0;
    unique case (state_r)
      psg_es_pkg::S_IDLE: begin
        if (in_accept) begin
          case (cmd)
            psg_es_pkg::CMD_TICK: begin
              v_nxt  = 2'd0;
              nu_nxt = 1'b0;
            end
            psg_es_pkg::CMD_LOAD: begin
              mem_wr_en = (in_voice_sel != psg_es_pkg::VOICE_AUTO) &&
                          (32'(in_slot_index) < MAX_STEPS);
            end
            psg_es_pkg::CMD_PLAY: begin
              ack_voice_nxt = 2'd0;
              ack_err_nxt   = psg_es_pkg::ERR_BAD;
              if (play_bad) begin
                ack_kind_nxt = psg_es_pkg::K_REFUSE;
              end else if ((play_v == 2'd0) && (spk_period_r != 12'd0)) begin
                ack_kind_nxt = psg_es_pkg::K_REFUSE;
                ack_err_nxt  = psg_es_pkg::ERR_BUSY;
              end else begin
                ack_kind_nxt        = psg_es_pkg::K_ACCEPT;
                ack_voice_nxt       = play_v;
                pd_we               = 1'b1;
                pending_nxt[play_v] = 1'b1;
              end
            end
            psg_es_pkg::CMD_STOP: begin
              for (int i = 0; i < 3; i++) begin
                if ((in_voice_sel == psg_es_pkg::VOICE_AUTO) || (in_voice_sel == 2'(i))) begin
                  pending_nxt[i] = 1'b0;
                  stopreq_nxt[i] = 1'b1;
                end
              end
            end
            psg_es_pkg::CMD_SPEAKER: begin
              if (in_tone_freq == 16'd0) begin
                spk_period_nxt = 12'd0;
                spk_dirty_nxt  = 1'b1;
              end else begin
                spk_level_nxt = psg_es_pkg::clamp_level(in_level);
                div_start     = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      psg_es_pkg::S_ACK: begin
        emit_en = 1'b1;
        e_kind  = ack_kind_r;
        e_voice = ack_voice_r;
        e_err   = ack_err_r;
      end
      psg_es_pkg::S_DONE: begin
        emit_en = 1'b1;
        e_kind  = psg_es_pkg::K_DONE;
        e_last  = 1'b1;
      end
      psg_es_pkg::S_DIV: begin
        if (div_res.done) begin
          spk_period_nxt = div_period;
          spk_dirty_nxt  = 1'b1;
        end
      end
      psg_es_pkg::S_SPK: begin
        if (spk_dirty_r) begin
          spk_dirty_nxt = 1'b0;
          if ((spk_period_r == 12'd0) && spk_running_r) begin
            spk_running_nxt = 1'b0;
            own_nxt[0]      = 1'b0;
            emit_en         = 1'b1;
            e_kind          = psg_es_pkg::K_RELEASE;
          end
        end
      end
      psg_es_pkg::S_SPK_STOP: begin
        k_nxt = 2'd0;
        if (running_r[0]) begin
          running_nxt[0] = 1'b0;
          if (own_r[0]) begin
            own_nxt[0] = 1'b0;
            emit_en    = 1'b1;
            e_kind     = psg_es_pkg::K_RELEASE;
          end
        end
      end
      psg_es_pkg::S_SPK_WR: begin
        k_nxt   = k_r + 2'd1;
        emit_en = 1'b1;
        case (k_r)
          2'd0: begin
            own_nxt[0] = 1'b1;
            e_kind     = psg_es_pkg::K_WRITE;
            e_addr     = psg_es_pkg::REG_TONE_A_LO;
            e_val      = spk_period_r[7:0];
          end
          2'd1: begin
            e_kind = psg_es_pkg::K_WRITE;
            e_addr = psg_es_pkg::REG_TONE_A_HI;
            e_val  = {4'd0, spk_period_r[11:8]};
          end
          2'd2: begin
            e_kind = psg_es_pkg::K_WRITE;
            e_addr = psg_es_pkg::REG_VOL_A;
            e_val  = {4'd0, spk_level_r};
          end
          default: begin
            e_kind          = psg_es_pkg::K_MIXER;
            e_addr          = psg_es_pkg::REG_MIXER;
            e_val           = psg_es_pkg::MIX_SPK_VAL;
            e_mask          = psg_es_pkg::MIX_SPK_MASK;
            spk_running_nxt = 1'b1;
          end
        endcase
      end
      psg_es_pkg::S_VSTOP: begin
        if (stopreq_r[v_r]) begin
          stopreq_nxt[v_r] = 1'b0;
          if (running_r[v_r]) begin
            running_nxt[v_r] = 1'b0;
            if (own_r[v_r]) begin
              own_nxt[v_r] = 1'b0;
              emit_en      = 1'b1;
              e_kind       = psg_es_pkg::K_RELEASE;
              e_voice      = v_r;
            end
          end
        end
      end
      psg_es_pkg::S_VPLAY: begin
        if (pending_r[v_r]) begin
          pending_nxt[v_r] = 1'b0;
          if (!((v_r == 2'd0) && spk_running_r)) begin
            ad_we            = 1'b1;
            pos_nxt[v_r]     = '0;
            acc_nxt[v_r]     = '0;
            running_nxt[v_r] = 1'b1;
            own_nxt[v_r]     = 1'b1;
            from_adv_nxt     = 1'b0;
          end
        end else if (running_r[v_r]) begin
          acc_nxt[v_r] = acc_r[v_r] + psg_es_pkg::TICK_MS;
        end
      end
      psg_es_pkg::S_ADV: begin
        if (running_r[v_r] && acc_ge) begin
          acc_nxt[v_r] = acc_r[v_r] - {1'b0, cur_dur};
          pos_nxt[v_r] = pos_inc;
          from_adv_nxt = 1'b1;
          if (pos_inc >= ad_total_r[v_r]) begin
            running_nxt[v_r] = 1'b0;
            if (own_r[v_r]) begin
              own_nxt[v_r] = 1'b0;
              emit_en      = 1'b1;
              e_kind       = psg_es_pkg::K_RELEASE;
              e_voice      = v_r;
            end
          end
        end
      end
      psg_es_pkg::S_RD: begin
        mem_rd_en = 1'b1;
        k_nxt     = 2'd0;
      end
      psg_es_pkg::S_STEP: begin
        k_nxt   = k_r + 2'd1;
        emit_en = 1'b1;
        e_kind  = psg_es_pkg::K_WRITE;
        if (step_period == 12'd0) begin
          e_addr = psg_es_pkg::REG_VOL_A + 4'(v_r);
        end else if (ad_noise_r[v_r] != 5'd0) begin
          case (k_r)
            2'd0: begin
              own_nxt[3] = 1'b1;
              e_addr     = psg_es_pkg::REG_NOISE;
              e_val      = {3'd0, ad_noise_r[v_r]};
            end
            2'd1: begin
              e_kind = psg_es_pkg::K_MIXER;
              e_addr = psg_es_pkg::REG_MIXER;
              e_val  = 8'(8'd1 << v_r);
              e_mask = 6'(psg_es_pkg::MIX_V_MASK << v_r);
            end
            default: begin
              e_addr = psg_es_pkg::REG_VOL_A + 4'(v_r);
              e_val  = {4'd0, step_vol};
            end
          endcase
        end else begin
          case (k_r)
            2'd0: begin
              e_addr = 4'({v_r, 1'b0});
              e_val  = step_period[7:0];
            end
            2'd1: begin
              e_addr = 4'({v_r, 1'b1});
              e_val  = {4'd0, step_period[11:8]};
            end
            2'd2: begin
              e_kind = psg_es_pkg::K_MIXER;
              e_addr = psg_es_pkg::REG_MIXER;
              e_val  = 8'(8'd8 << v_r);
              e_mask = 6'(psg_es_pkg::MIX_V_MASK << v_r);
            end
            default: begin
              e_addr = psg_es_pkg::REG_VOL_A + 4'(v_r);
              e_val  = {4'd0, step_vol};
            end
          endcase
        end
      end
      psg_es_pkg::S_VNOISE: begin
        nu_nxt = nu_cur;
        v_nxt  = v_r + 2'd1;
        if ((v_r == 2'd2) && !nu_cur) begin
          own_nxt[3] = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= psg_es_pkg::S_IDLE;
      running_r     <= '0;
      pending_r     <= '0;
      stopreq_r     <= '0;
      own_r         <= '0;
      spk_period_r  <= '0;
      spk_dirty_r   <= 1'b0;
      spk_running_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (commit) begin
        state_r       <= state_nxt;
        running_r     <= running_nxt;
        pending_r     <= pending_nxt;
        stopreq_r     <= stopreq_nxt;
        own_r         <= own_nxt;
        spk_period_r  <= spk_period_nxt;
        spk_dirty_r   <= spk_dirty_nxt;
        spk_running_r <= spk_running_nxt;
      end
      if (out_free) begin
        out_valid_r <= emit_en;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      v_r         <= v_nxt;
      k_r         <= k_nxt;
      nu_r        <= nu_nxt;
      from_adv_r  <= from_adv_nxt;
      spk_level_r <= spk_level_nxt;
      ack_kind_r  <= ack_kind_nxt;
      ack_voice_r <= ack_voice_nxt;
      ack_err_r   <= ack_err_nxt;
      pos_r       <= pos_nxt;
      acc_r       <= acc_nxt;
    end
    if (pd_we) begin
      pd_table_r[pd_sel] <= in_use_level_table;
      pd_noise_r[pd_sel] <= in_noise_rate;
      pd_total_r[pd_sel] <= sat_total;
      pd_dur_r[pd_sel]   <= eff_dur;
      pd_level_r[pd_sel] <= psg_es_pkg::clamp_level(in_level);
    end
    if (ad_we && commit) begin
      ad_table_r[v_r] <= pd_table_r[v_r];
      ad_noise_r[v_r] <= pd_noise_r[v_r];
      ad_total_r[v_r] <= pd_total_r[v_r];
      ad_dur_r[v_r]   <= pd_dur_r[v_r];
      ad_level_r[v_r] <= pd_level_r[v_r];
    end
    if (emit_en && out_free) begin
      out_kind_r  <= e_kind;
      out_addr_r  <= e_addr;
      out_val_r   <= e_val;
      out_mask_r  <= e_mask;
      out_voice_r <= e_voice;
      out_err_r   <= e_err;
      out_own_r   <= own_nxt;
      out_act_r   <= running_nxt | pending_nxt;
      out_last_r  <= e_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = out_kind_r;
  assign out_reg_addr    = out_addr_r;
  assign out_reg_value   = out_val_r;
  assign out_mix_mask    = out_mask_r;
  assign out_voice_out   = out_voice_r;
  assign out_error_code  = out_err_r;
  assign out_owned_mask  = out_own_r;
  assign out_active_mask = out_act_r;
  assign out_last        = out_last_r;

`ifndef NO_ASSERTIONS
  a_div_only_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_res.busy |-> (state_r == psg_es_pkg::S_DIV))
    else $error("divider busy outside speaker division");

  a_step_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == psg_es_pkg::S_STEP) |->
      ($past(state_r) == psg_es_pkg::S_RD || $past(state_r) == psg_es_pkg::S_STEP))
    else $error("step words without a preceding memory read");

  a_ack_then_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == psg_es_pkg::S_ACK) && out_free |=> (state_r == psg_es_pkg::S_DONE))
    else $error("play acknowledge not followed by done");
`endif

endmodule
